FILE: design/imf_pkg.sv
`timescale 1ns / 1ps
package imf_pkg;

  typedef struct packed {
    logic        mode;
    logic [63:0] leaf_w0;
    logic [63:0] leaf_w1;
    logic [63:0] leaf_w2;
    logic [63:0] leaf_w3;
  } in_item_t;

  typedef struct packed {
    logic [63:0] root_w0;
    logic [63:0] root_w1;
    logic [63:0] root_w2;
    logic [63:0] root_w3;
    logic [32:0] leaf_count;
    logic        status;
  } out_item_t;

  localparam logic MODE_APPEND = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;
  localparam logic [5:0] DEPTH_RESET = 6'd29;
  localparam logic [5:0] DEPTH_MIN   = 6'd2;

  localparam logic [255:0] SHA_IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] sha_k(input logic [5:0] i);
    logic [31:0] k;
    unique case (i)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

endpackage

FILE: design/incremental_merkle_frontier_top.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Beat
// in        input      in_valid / in_ready    in_data   (imf_pkg::in_item_t)
// out       output     out_valid / out_ready  out_data  (imf_pkg::out_item_t)
// cfg       input      cfg_we                 cfg_data  (tree_depth)
// After reset the empty-subtree table is built with in_ready low: MAX_LEVELS
// hashes in the one shared round unit, which serves every hash of the block.
// An append takes 0 to 31 hashes and a query 2 to 32 hashes; an append without
// a hash goes straight from idle to the output state. One item is in flight at
// a time; a result waiting in the output register does not block the next input,
// whose result waits only while the earlier beat is still unaccepted.
module incremental_merkle_frontier_top #(
  parameter int MAX_LEVELS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  imf_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output imf_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [5:0]         cfg_data
);
  import imf_pkg::*;

  localparam int LW = $clog2(MAX_LEVELS);
  localparam int EW = $clog2(MAX_LEVELS + 1);
  localparam logic [5:0] MAXL = 6'(MAX_LEVELS);

  typedef enum logic [3:0] {
    S_INIT, S_INIT_WAIT, S_IDLE, S_AP_RD, S_AP_HASH, S_AP_NEXT,
    S_Q_RD, S_Q_HASH, S_Q_NEXT, S_OUT
  } state_t;

  state_t state;
  logic [5:0]   tree_depth;
  logic [255:0] left_leaf, right_leaf, acc, leaf_in;
  logic         left_valid, right_valid;
  logic [MAX_LEVELS-1:0] level_valid;
  logic [MAX_LEVELS-1:0] level_live;
  logic [5:0]   levels_used, lvl, dcnt;
  logic         busy_out;
  logic         out_load;
  out_item_t    res;
  out_item_t    out_reg;

  logic         sha_start, sha_done;
  logic [511:0] sha_block;
  logic [255:0] sha_digest;

  logic         lh_we, er_we;
  logic [LW-1:0] lh_waddr, lh_raddr;
  logic [EW-1:0] er_waddr, er_raddr;
  logic [255:0] lh_wdata, er_wdata, lh_rdata, er_rdata;

  imf_sha u_sha (
    .clk(clk), .rst(rst), .start(sha_start), .block(sha_block),
    .done(sha_done), .digest(sha_digest)
  );

  imf_ram #(.WIDTH(256), .DEPTH(MAX_LEVELS)) u_levels (
    .clk(clk), .we(lh_we), .waddr(lh_waddr), .wdata(lh_wdata),
    .raddr(lh_raddr), .rdata(lh_rdata)
  );

  imf_ram #(.WIDTH(256), .DEPTH(MAX_LEVELS + 1)) u_empty (
    .clk(clk), .we(er_we), .waddr(er_waddr), .wdata(er_wdata),
    .raddr(er_raddr), .rdata(er_rdata)
  );

  logic [5:0]  eff_depth;
  logic [33:0] count, cap;

  always_comb begin
    eff_depth = tree_depth;
    if (eff_depth < DEPTH_MIN) begin
      eff_depth = DEPTH_MIN;
    end
    if (eff_depth > MAXL) begin
      eff_depth = MAXL;
    end
    for (int i = 0; i < MAX_LEVELS; i++) begin
      level_live[i] = level_valid[i] && (6'(i) < levels_used);
    end
    count = 34'({level_live, 1'b0}) + 34'(left_valid) + 34'(right_valid);
    cap = 34'd1 << eff_depth;
  end

  assign in_ready = (state == S_IDLE);
  assign out_valid = busy_out;
  assign out_data = out_reg;
  assign out_load = (state == S_OUT) && (!busy_out || out_ready);

  logic lvl_in;
  assign lvl_in = (lvl < levels_used) && level_valid[lvl[LW-1:0]];

  always_ff @(posedge clk) begin
    sha_start <= 1'b0;
    lh_we <= 1'b0;
    er_we <= 1'b0;
    if (rst) begin
      state <= S_INIT;
      tree_depth <= DEPTH_RESET;
      left_valid <= 1'b0;
      right_valid <= 1'b0;
      level_valid <= '0;
      levels_used <= '0;
      busy_out <= 1'b0;
      lvl <= '0;
      dcnt <= '0;
      er_we <= 1'b1;
      er_waddr <= '0;
      er_wdata <= '0;
      acc <= '0;
    end else begin
      if (cfg_we) begin
        tree_depth <= cfg_data;
      end
      if (out_load) begin
        busy_out <= 1'b1;
      end else if (out_ready) begin
        busy_out <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          sha_block <= {acc, acc};
          sha_start <= 1'b1;
          state <= S_INIT_WAIT;
        end
        S_INIT_WAIT: begin
          if (sha_done) begin
            acc <= sha_digest;
            er_we <= 1'b1;
            er_waddr <= EW'(dcnt + 6'd1);
            er_wdata <= sha_digest;
            dcnt <= dcnt + 6'd1;
            state <= (dcnt + 6'd1 == MAXL) ? S_IDLE : S_INIT;
          end
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            leaf_in <= {in_data.leaf_w0, in_data.leaf_w1, in_data.leaf_w2, in_data.leaf_w3};
            res <= '{root_w0: '0, root_w1: '0, root_w2: '0, root_w3: '0,
                     leaf_count: '0,
                     status: (in_data.mode == MODE_APPEND) && (count >= cap)};
            lvl <= '0;
            if (in_data.mode == MODE_APPEND) begin
              if (count >= cap) begin
                state <= S_OUT;
              end else if (!left_valid) begin
                left_leaf <= {in_data.leaf_w0, in_data.leaf_w1, in_data.leaf_w2,
                              in_data.leaf_w3};
                left_valid <= 1'b1;
                state <= S_OUT;
              end else if (!right_valid) begin
                right_leaf <= {in_data.leaf_w0, in_data.leaf_w1, in_data.leaf_w2,
                               in_data.leaf_w3};
                right_valid <= 1'b1;
                state <= S_OUT;
              end else begin
                sha_block <= {left_leaf, right_leaf};
                sha_start <= 1'b1;
                state <= S_AP_HASH;
              end
            end else begin
              er_raddr <= '0;
              dcnt <= '0;
              state <= S_Q_RD;
            end
          end
        end
        S_AP_HASH: begin
          if (sha_done) begin
            acc <= sha_digest;
            lh_raddr <= lvl[LW-1:0];
            state <= S_AP_RD;
          end
        end
        S_AP_RD: begin
          state <= S_AP_NEXT;
        end
        S_AP_NEXT: begin
          if (lvl == 6'd0) begin
            left_leaf <= leaf_in;
            right_valid <= 1'b0;
          end
          if (lvl_in) begin
            level_valid[lvl[LW-1:0]] <= 1'b0;
            sha_block <= {lh_rdata, acc};
            sha_start <= 1'b1;
            lvl <= lvl + 6'd1;
            state <= S_AP_HASH;
          end else begin
            lh_we <= 1'b1;
            lh_waddr <= lvl[LW-1:0];
            lh_wdata <= acc;
            level_valid[lvl[LW-1:0]] <= 1'b1;
            if (lvl >= levels_used) begin
              levels_used <= lvl + 6'd1;
            end
            state <= S_OUT;
          end
        end
        S_Q_RD: begin
          state <= S_Q_NEXT;
        end
        S_Q_NEXT: begin
          if (dcnt == 6'd0) begin
            sha_block <= {left_valid ? left_leaf : er_rdata,
                          right_valid ? right_leaf : er_rdata};
            sha_start <= 1'b1;
            dcnt <= 6'd1;
            state <= S_Q_HASH;
          end else if (lvl < levels_used) begin
            sha_block <= lvl_in ? {lh_rdata, acc} : {acc, er_rdata};
            sha_start <= 1'b1;
            lvl <= lvl + 6'd1;
            dcnt <= dcnt + 6'd1;
            state <= S_Q_HASH;
          end else if (dcnt < eff_depth) begin
            sha_block <= {acc, er_rdata};
            sha_start <= 1'b1;
            dcnt <= dcnt + 6'd1;
            state <= S_Q_HASH;
          end else begin
            {res.root_w0, res.root_w1, res.root_w2, res.root_w3} <= acc;
            state <= S_OUT;
          end
        end
        S_Q_HASH: begin
          if (sha_done) begin
            acc <= sha_digest;
            lh_raddr <= lvl[LW-1:0];
            er_raddr <= (dcnt > MAXL) ? EW'(MAXL) : EW'(dcnt);
            state <= S_Q_RD;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_reg <= '{root_w0: res.root_w0, root_w1: res.root_w1,
                         root_w2: res.root_w2, root_w3: res.root_w3,
                         leaf_count: count[32:0], status: res.status};
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: design/imf_ram.sv
`timescale 1ns / 1ps
module imf_ram #(
  parameter int WIDTH = 256,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: design/imf_sha.sv
`timescale 1ns / 1ps
module imf_sha (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [511:0] block,
  output logic         done,
  output logic [255:0] digest
);
  import imf_pkg::*;

  logic [31:0]  w [16];
  logic [31:0]  a, b, c, d, e, f, g, h;
  logic [5:0]   rnd;
  logic         busy;
  logic [31:0]  t1, t2, s0, s1, wn;

  function automatic logic [31:0] rr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  always_comb begin
    t1 = h + (rr(e, 6) ^ rr(e, 11) ^ rr(e, 25)) + ((e & f) ^ (~e & g)) + sha_k(rnd) + w[0];
    t2 = (rr(a, 2) ^ rr(a, 13) ^ rr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
    s0 = rr(w[1], 7) ^ rr(w[1], 18) ^ (w[1] >> 3);
    s1 = rr(w[14], 17) ^ rr(w[14], 19) ^ (w[14] >> 10);
    wn = w[0] + s0 + w[9] + s1;
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      rnd  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      rnd  <= '0;
      for (int i = 0; i < 16; i++) begin
        w[i] <= block[511 - 32*i -: 32];
      end
      {a, b, c, d, e, f, g, h} <= SHA_IV;
    end else if (busy) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i+1];
      end
      w[15] <= wn;
      h <= g; g <= f; f <= e; e <= d + t1;
      d <= c; c <= b; b <= a; a <= t1 + t2;
      rnd <= rnd + 6'd1;
      if (rnd == 6'd63) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_comb begin
    digest = {SHA_IV[255:224] + a, SHA_IV[223:192] + b, SHA_IV[191:160] + c,
              SHA_IV[159:128] + d, SHA_IV[127:96] + e, SHA_IV[95:64] + f,
              SHA_IV[63:32] + g, SHA_IV[31:0] + h};
  end
endmodule
